[src/closed_polyline_arc_length_mapper_top_assert.svh]
// Assertion macros for the polyline mapper
`ifndef CLOSED_POLYLINE_ARC_LENGTH_MAPPER_TOP_ASSERT_SVH
`define CLOSED_POLYLINE_ARC_LENGTH_MAPPER_TOP_ASSERT_SVH

// same-cycle implication
`define CPLAM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPLAM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cplam_pkg.sv]
`default_nettype none

package cplam_pkg;

  // field widths
  localparam int CMD_W   = 2;
  localparam int IDX_W   = 8;
  localparam int COORD_W = 24;
  localparam int QD_W    = 25;
  localparam int STAT_W  = 2;
  localparam int DIR_W   = 16;
  localparam int CNT_W   = 9;

  // commands
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ALONG = 2'd1;
  localparam logic [CMD_W-1:0] CMD_POINT = 2'd2;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_ORDER      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_LOADED = 2'd2;

  // distance saturation
  localparam logic [COORD_W-1:0] DIST_MAX = 24'hFFFFFF;

endpackage

`default_nettype wire

[src/closed_polyline_arc_length_mapper_top.sv]
// Channel  | Dir | Handshake               | Word
// in       | in  | in_valid_i / in_stall_o  | command, point_index, x, y, query_distance
// out      | out | out_valid_o / out_stall_i| status, along, point x/y, dir x/y
// cfg      | in  | APB psel/penable/pwrite  | point_count at byte address 0
//
// One word at a time; in_stall_o is high from acceptance until the result is registered.
// Load: one isqrt of 31 steps for each segment length.
// Distance-along: per segment a 16-step divide for t, and an isqrt on a new best.
// Point-at-distance: a scan, then 25-, 51- and 46-step divides and one isqrt.
// Reset clears the path (no points loaded, lap 0) and sets point_count to 2.
// A result held by out_stall_i does not stop the next word from being accepted.
`default_nettype none
`include "closed_polyline_arc_length_mapper_top_assert.svh"

module closed_polyline_arc_length_mapper_top #(
  parameter int MAX_POINTS = 256
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  // input channel
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire  [cplam_pkg::CMD_W-1:0]           command_i,
  input  wire  [cplam_pkg::IDX_W-1:0]           point_index_i,
  input  wire  signed [cplam_pkg::COORD_W-1:0]  x_coord_i,
  input  wire  signed [cplam_pkg::COORD_W-1:0]  y_coord_i,
  input  wire  signed [cplam_pkg::QD_W-1:0]     query_distance_i,
  // output channel
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output logic [cplam_pkg::STAT_W-1:0]          status_o,
  output logic [cplam_pkg::COORD_W-1:0]         along_distance_o,
  output logic signed [cplam_pkg::COORD_W-1:0]  point_x_o,
  output logic signed [cplam_pkg::COORD_W-1:0]  point_y_o,
  output logic signed [cplam_pkg::DIR_W-1:0]    dir_x_o,
  output logic signed [cplam_pkg::DIR_W-1:0]    dir_y_o,
  // configuration
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [2:0]                            paddr,
  input  wire  [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  import cplam_pkg::*;

  localparam int AW        = $clog2(MAX_POINTS);
  localparam int IDX_LIMIT = (MAX_POINTS < 256) ? MAX_POINTS : 256;

  typedef enum logic [5:0] {
    S_IDLE, S_DECODE,
    S_LD_RD, S_LD_DIFF, S_LD_SQ, S_LD_SUM, S_LD_RD0, S_LD_CLOSE, S_LD_SQ2, S_LD_LAP,
    S_LSQ0, S_LSQ1, S_LSQ2, S_SQRT, S_DIV,
    S_A_RDA, S_A_RDB, S_A_DIFF, S_A_DOT0, S_A_DOT1, S_A_DOT2, S_A_T, S_A_TQ,
    S_A_QX0, S_A_QX1, S_A_QY, S_A_EX, S_A_EY, S_A_ALONG0, S_A_ALONG1, S_A_NEXT,
    S_P_MOD, S_P_SCANRD, S_P_SCANCHK, S_P_RDA, S_P_RDB, S_P_DIFF, S_P_SQ, S_P_R,
    S_P_MX0, S_P_MX1, S_P_MXQ, S_P_MY1, S_P_MYQ, S_P_DIR, S_P_DXQ, S_P_DYQ,
    S_DONE
  } state_e;

  // control
  state_e             state_q, ret_q;
  logic [CMD_W-1:0]   cmd_q;
  logic [IDX_W-1:0]   idx_q, seg_q;
  logic [CNT_W-1:0]   n_q, loaded_q;
  logic [COORD_W-1:0] lap_q;
  logic               have_q, out_valid_q;

  // operands and working values
  logic signed [COORD_W-1:0] lx_q, ly_q, ax_q, ay_q, qx_q, qy_q;
  logic signed [QD_W-1:0]    qd_q;
  logic [COORD_W-1:0]        cum_q, w_q, r_q;
  logic signed [24:0]        dx_q, dy_q;
  logic [49:0]               lsq_q;
  logic signed [50:0]        dot_q;
  logic [16:0]               t_q;
  logic [51:0]               dsq_q, best_q;
  logic [24:0]               len_q;
  logic [30:0]               fl_q;
  logic                      sgn_q;

  // result being built and output register
  logic [STAT_W-1:0]         status_q, out_status_q;
  logic [COORD_W-1:0]        along_q, out_along_q;
  logic signed [COORD_W-1:0] px_q, py_q, out_px_q, out_py_q;
  logic signed [DIR_W-1:0]   dirx_q, diry_q, out_dirx_q, out_diry_q;

  // shared divider
  logic [49:0] div_rem_q, div_den_q;
  logic [63:0] div_num_q;
  logic [51:0] div_quo_q;
  logic [6:0]  div_cnt_q;

  // shared square root
  logic [60:0] sq_v_q, sq_res_q, sq_bit_q;

  // shared multiplier
  logic signed [25:0] mul_a, mul_b;
  logic signed [51:0] prod_q;

  // path memories
  logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
  logic signed [COORD_W-1:0] mem_y [MAX_POINTS];
  logic [COORD_W-1:0]        mem_cum [MAX_POINTS];
  logic signed [COORD_W-1:0] rd_x_q, rd_y_q;
  logic [COORD_W-1:0]        rd_cum_q;
  logic [AW-1:0]             rd_addr, wr_addr;
  logic                      wr_xy, wr_cum;
  logic [COORD_W-1:0]        wr_cum_data;

  // helpers
  function automatic logic [COORD_W-1:0] sat24(input logic [27:0] v);
    return (v > 28'(DIST_MAX)) ? DIST_MAX : v[COORD_W-1:0];
  endfunction

  // round(p / 65536), half away from zero
  function automatic logic signed [26:0] rnd16(input logic signed [51:0] p);
    logic [51:0] mag;
    logic [51:0] q;
    mag = p[51] ? 52'(-p) : 52'(p);
    q   = (mag + 52'd32768) >> 16;
    return p[51] ? -27'(q) : 27'(q);
  endfunction

  function automatic logic signed [24:0] diff25(input logic signed [23:0] a,
                                                input logic signed [23:0] b);
    return {a[23], a} - {b[23], b};
  endfunction

  // load checks
  logic             restart, ld_ok;
  logic [CNT_W-1:0] eff_loaded;
  assign restart    = (loaded_q >= n_q) && (idx_q == '0);
  assign eff_loaded = restart ? '0 : loaded_q;
  assign ld_ok      = ({1'b0, idx_q} == eff_loaded) && (eff_loaded < n_q) &&
                      (32'(idx_q) < MAX_POINTS);

  // next segment index with wrap
  logic [CNT_W-1:0] seg_inc, seg_nxt;
  assign seg_inc = {1'b0, seg_q} + 9'd1;
  assign seg_nxt = (seg_inc == n_q) ? '0 : seg_inc;

  // divider step
  logic [50:0] div_sh;
  logic        div_ge;
  assign div_sh = {div_rem_q, div_num_q[63]};
  assign div_ge = div_sh >= {1'b0, div_den_q};

  // square-root step
  logic [61:0] sq_sum;
  logic        sq_ge;
  logic [60:0] sq_res_n;
  assign sq_sum   = {1'b0, sq_res_q} + {1'b0, sq_bit_q};
  assign sq_ge    = {1'b0, sq_v_q} >= sq_sum;
  assign sq_res_n = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);

  // running sums
  logic [27:0] cum_len;
  logic [51:0] dsq_sum;
  logic [42:0] al_rnd;
  logic [27:0] al_sum;
  logic [49:0] mod_rem;
  logic [50:0] pmag;
  logic [24:0] dx_abs, dy_abs;
  assign cum_len = 28'(cum_q) + 28'(len_q);
  assign dsq_sum = dsq_q + 52'(prod_q);
  assign al_rnd  = {1'b0, prod_q[41:0]} + 43'd32768;
  assign al_sum  = 28'(cum_q) + 28'(al_rnd[42:16]);
  assign mod_rem = div_rem_q;
  assign pmag    = prod_q[51] ? 51'(-prod_q) : 51'(prod_q);
  assign dx_abs  = dx_q[24] ? 25'(-dx_q) : 25'(dx_q);
  assign dy_abs  = dy_q[24] ? 25'(-dy_q) : 25'(dy_q);

  // multiplier operands by state
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_LSQ0:     begin mul_a = 26'(dx_q); mul_b = 26'(dx_q); end
      S_LSQ1:     begin mul_a = 26'(dy_q); mul_b = 26'(dy_q); end
      S_A_DOT0:   begin mul_a = 26'(diff25(lx_q, ax_q)); mul_b = 26'(dx_q); end
      S_A_DOT1:   begin mul_a = 26'(diff25(ly_q, ay_q)); mul_b = 26'(dy_q); end
      S_A_QX0:    begin mul_a = 26'(dx_q); mul_b = {9'b0, t_q}; end
      S_A_QX1:    begin mul_a = 26'(dy_q); mul_b = {9'b0, t_q}; end
      S_A_QY:     begin
        mul_a = 26'(diff25(lx_q, qx_q));
        mul_b = 26'(diff25(lx_q, qx_q));
      end
      S_A_EX:     begin
        mul_a = 26'(diff25(ly_q, qy_q));
        mul_b = 26'(diff25(ly_q, qy_q));
      end
      S_A_ALONG0: begin mul_a = {1'b0, len_q}; mul_b = {9'b0, t_q}; end
      S_P_MX0:    begin mul_a = 26'(dx_q); mul_b = {2'b0, r_q}; end
      S_P_MXQ:    begin mul_a = 26'(dy_q); mul_b = {2'b0, r_q}; end
      default:    begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // memory addressing
  always_comb begin
    rd_addr = '0;
    case (state_q)
      S_LD_RD:    rd_addr = AW'(seg_q);
      S_A_RDA:    rd_addr = AW'(seg_q);
      S_A_RDB:    rd_addr = AW'(seg_nxt);
      S_P_SCANRD: rd_addr = AW'(seg_inc);
      S_P_RDA:    rd_addr = AW'(seg_q);
      S_P_RDB:    rd_addr = AW'(seg_nxt);
      default:    rd_addr = '0;
    endcase
  end

  assign wr_addr     = AW'(idx_q);
  assign wr_xy       = (state_q == S_DECODE) && (cmd_q == CMD_LOAD) && ld_ok;
  assign wr_cum      = (wr_xy && (idx_q == '0)) || (state_q == S_LD_SUM);
  assign wr_cum_data = (state_q == S_LD_SUM) ? sat24(cum_len) : '0;

  always_ff @(posedge clk_i) begin
    if (wr_xy) begin
      mem_x[wr_addr] <= x_coord_q_w();
      mem_y[wr_addr] <= ly_q;
    end
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_cum) begin
      mem_cum[wr_addr] <= wr_cum_data;
    end
    rd_cum_q <= mem_cum[rd_addr];
  end

  function automatic logic signed [COORD_W-1:0] x_coord_q_w();
    return lx_q;
  endfunction

  // sequencer
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= 9'd2;
      loaded_q    <= '0;
      lap_q       <= '0;
      have_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q    <= command_i;
            idx_q    <= point_index_i;
            lx_q     <= x_coord_i;
            ly_q     <= y_coord_i;
            qd_q     <= query_distance_i;
            status_q <= ST_OK;
            along_q  <= '0;
            px_q     <= '0;
            py_q     <= '0;
            dirx_q   <= '0;
            diry_q   <= '0;
            state_q  <= S_DECODE;
          end
        end
        S_DECODE: begin
          case (cmd_q)
            CMD_LOAD: begin
              if (restart) begin
                loaded_q <= '0;
                lap_q    <= '0;
              end
              if (!ld_ok) begin
                status_q <= ST_ORDER;
                state_q  <= S_DONE;
              end else if (idx_q == '0) begin
                loaded_q <= eff_loaded + 9'd1;
                state_q  <= S_DONE;
              end else begin
                seg_q   <= idx_q - 8'd1;
                state_q <= S_LD_RD;
              end
            end
            CMD_ALONG, CMD_POINT: begin
              if (loaded_q != n_q) begin
                status_q <= ST_NOT_LOADED;
                state_q  <= S_DONE;
              end else if (cmd_q == CMD_ALONG) begin
                seg_q   <= '0;
                have_q  <= 1'b0;
                state_q <= S_A_RDA;
              end else if (lap_q == '0) begin
                w_q     <= '0;
                seg_q   <= '0;
                state_q <= S_P_SCANRD;
              end else begin
                div_rem_q <= '0;
                div_num_q <= {(qd_q[24] ? 25'(-qd_q) : 25'(qd_q)), 39'b0};
                div_den_q <= 50'(lap_q);
                div_quo_q <= '0;
                div_cnt_q <= 7'd25;
                ret_q     <= S_P_MOD;
                state_q   <= S_DIV;
              end
            end
            default: state_q <= S_DONE;
          endcase
        end

        // ---- load ----
        S_LD_RD: state_q <= S_LD_DIFF;
        S_LD_DIFF: begin
          dx_q    <= diff25(lx_q, rd_x_q);
          dy_q    <= diff25(ly_q, rd_y_q);
          cum_q   <= rd_cum_q;
          ret_q   <= S_LD_SQ;
          state_q <= S_LSQ0;
        end
        S_LD_SQ: begin
          sq_v_q   <= {lsq_q[48:0], 12'b0};
          sq_res_q <= '0;
          sq_bit_q <= {1'b1, 60'b0};
          ret_q    <= S_LD_SUM;
          state_q  <= S_SQRT;
        end
        S_LD_SUM: begin
          along_q  <= sat24(cum_len);
          cum_q    <= sat24(cum_len);
          loaded_q <= loaded_q + 9'd1;
          state_q  <= (loaded_q + 9'd1 == n_q) ? S_LD_RD0 : S_DONE;
        end
        S_LD_RD0: state_q <= S_LD_CLOSE;
        S_LD_CLOSE: begin
          dx_q    <= diff25(rd_x_q, lx_q);
          dy_q    <= diff25(rd_y_q, ly_q);
          ret_q   <= S_LD_SQ2;
          state_q <= S_LSQ0;
        end
        S_LD_SQ2: begin
          sq_v_q   <= {lsq_q[48:0], 12'b0};
          sq_res_q <= '0;
          sq_bit_q <= {1'b1, 60'b0};
          ret_q    <= S_LD_LAP;
          state_q  <= S_SQRT;
        end
        S_LD_LAP: begin
          lap_q   <= sat24(cum_len);
          state_q <= S_DONE;
        end

        // ---- shared squared length ----
        S_LSQ0: state_q <= S_LSQ1;
        S_LSQ1: begin
          lsq_q   <= 50'(prod_q);
          state_q <= S_LSQ2;
        end
        S_LSQ2: begin
          lsq_q   <= lsq_q + 50'(prod_q);
          state_q <= ret_q;
        end

        // ---- shared isqrt, two bits a step ----
        S_SQRT: begin
          if (sq_ge) begin
            sq_v_q <= sq_v_q - sq_sum[60:0];
          end
          sq_res_q <= sq_res_n;
          sq_bit_q <= sq_bit_q >> 2;
          if (sq_bit_q[0]) begin
            fl_q    <= sq_res_n[30:0];
            len_q   <= 25'((sq_res_n[31:0] + 32'd32) >> 6);
            state_q <= ret_q;
          end
        end

        // ---- shared restoring divider, one bit a step ----
        S_DIV: begin
          div_rem_q <= div_ge ? 50'(div_sh - {1'b0, div_den_q}) : div_sh[49:0];
          div_num_q <= div_num_q << 1;
          div_quo_q <= {div_quo_q[50:0], div_ge};
          div_cnt_q <= div_cnt_q - 7'd1;
          if (div_cnt_q == 7'd1) begin
            state_q <= ret_q;
          end
        end

        // ---- distance along ----
        S_A_RDA: state_q <= S_A_RDB;
        S_A_RDB: begin
          ax_q    <= rd_x_q;
          ay_q    <= rd_y_q;
          cum_q   <= rd_cum_q;
          state_q <= S_A_DIFF;
        end
        S_A_DIFF: begin
          dx_q    <= diff25(rd_x_q, ax_q);
          dy_q    <= diff25(rd_y_q, ay_q);
          ret_q   <= S_A_DOT0;
          state_q <= S_LSQ0;
        end
        S_A_DOT0: state_q <= S_A_DOT1;
        S_A_DOT1: begin
          dot_q   <= 51'(prod_q);
          state_q <= S_A_DOT2;
        end
        S_A_DOT2: begin
          dot_q   <= dot_q + 51'(prod_q);
          state_q <= S_A_T;
        end
        S_A_T: begin
          if ((lsq_q == '0) || dot_q[50] || (dot_q == '0)) begin
            t_q     <= '0;
            state_q <= S_A_QX0;
          end else if ($unsigned(dot_q) >= {1'b0, lsq_q}) begin
            t_q     <= 17'h10000;
            state_q <= S_A_QX0;
          end else begin
            div_rem_q <= dot_q[49:0];
            div_num_q <= '0;
            div_den_q <= lsq_q;
            div_quo_q <= '0;
            div_cnt_q <= 7'd16;
            ret_q     <= S_A_TQ;
            state_q   <= S_DIV;
          end
        end
        S_A_TQ: begin
          t_q     <= div_quo_q[16:0];
          state_q <= S_A_QX0;
        end
        S_A_QX0: state_q <= S_A_QX1;
        S_A_QX1: begin
          qx_q    <= 24'({{3{ax_q[23]}}, ax_q} + rnd16(prod_q));
          state_q <= S_A_QY;
        end
        S_A_QY: begin
          qy_q    <= 24'({{3{ay_q[23]}}, ay_q} + rnd16(prod_q));
          state_q <= S_A_EX;
        end
        S_A_EX: begin
          dsq_q   <= 52'(prod_q);
          state_q <= S_A_EY;
        end
        S_A_EY: begin
          if (!have_q || (dsq_sum < best_q)) begin
            have_q   <= 1'b1;
            best_q   <= dsq_sum;
            sq_v_q   <= {lsq_q[48:0], 12'b0};
            sq_res_q <= '0;
            sq_bit_q <= {1'b1, 60'b0};
            ret_q    <= S_A_ALONG0;
            state_q  <= S_SQRT;
          end else begin
            state_q <= S_A_NEXT;
          end
        end
        S_A_ALONG0: state_q <= S_A_ALONG1;
        S_A_ALONG1: begin
          along_q <= sat24(al_sum);
          state_q <= S_A_NEXT;
        end
        S_A_NEXT: begin
          if (seg_inc == n_q) begin
            state_q <= S_DONE;
          end else begin
            seg_q   <= seg_inc[IDX_W-1:0];
            state_q <= S_A_RDA;
          end
        end

        // ---- point at distance ----
        S_P_MOD: begin
          if (qd_q[24] && (mod_rem != '0)) begin
            w_q <= lap_q - mod_rem[23:0];
          end else begin
            w_q <= mod_rem[23:0];
          end
          seg_q   <= '0;
          state_q <= S_P_SCANRD;
        end
        S_P_SCANRD: state_q <= S_P_SCANCHK;
        S_P_SCANCHK: begin
          if (w_q < rd_cum_q) begin
            state_q <= S_P_RDA;
          end else if (seg_inc + 9'd1 == n_q) begin
            seg_q   <= 8'(n_q - 9'd1);
            state_q <= S_P_RDA;
          end else begin
            seg_q   <= seg_inc[IDX_W-1:0];
            state_q <= S_P_SCANRD;
          end
        end
        S_P_RDA: state_q <= S_P_RDB;
        S_P_RDB: begin
          ax_q    <= rd_x_q;
          ay_q    <= rd_y_q;
          cum_q   <= rd_cum_q;
          state_q <= S_P_DIFF;
        end
        S_P_DIFF: begin
          dx_q    <= diff25(rd_x_q, ax_q);
          dy_q    <= diff25(rd_y_q, ay_q);
          ret_q   <= S_P_SQ;
          state_q <= S_LSQ0;
        end
        S_P_SQ: begin
          sq_v_q   <= {lsq_q[48:0], 12'b0};
          sq_res_q <= '0;
          sq_bit_q <= {1'b1, 60'b0};
          ret_q    <= S_P_R;
          state_q  <= S_SQRT;
        end
        S_P_R: begin
          along_q <= w_q;
          r_q     <= (w_q > cum_q) ? (w_q - cum_q) : '0;
          if (len_q == '0) begin
            px_q    <= ax_q;
            py_q    <= ay_q;
            state_q <= S_P_DIR;
          end else if (25'((w_q > cum_q) ? (w_q - cum_q) : '0) >= len_q) begin
            px_q    <= 24'({ax_q[23], ax_q} + dx_q);
            py_q    <= 24'({ay_q[23], ay_q} + dy_q);
            state_q <= S_P_DIR;
          end else begin
            state_q <= S_P_MX0;
          end
        end
        S_P_MX0: state_q <= S_P_MX1;
        S_P_MX1, S_P_MY1: begin
          sgn_q     <= prod_q[51];
          div_rem_q <= '0;
          div_num_q <= {pmag + {26'b0, len_q[24:1]}, 13'b0};
          div_den_q <= 50'(len_q);
          div_quo_q <= '0;
          div_cnt_q <= 7'd51;
          ret_q     <= (state_q == S_P_MX1) ? S_P_MXQ : S_P_MYQ;
          state_q   <= S_DIV;
        end
        S_P_MXQ: begin
          px_q    <= 24'({{3{ax_q[23]}}, ax_q} +
                         (sgn_q ? -{2'b0, div_quo_q[24:0]} : {2'b0, div_quo_q[24:0]}));
          state_q <= S_P_MY1;
        end
        S_P_MYQ: begin
          py_q    <= 24'({{3{ay_q[23]}}, ay_q} +
                         (sgn_q ? -{2'b0, div_quo_q[24:0]} : {2'b0, div_quo_q[24:0]}));
          state_q <= S_P_DIR;
        end
        S_P_DIR: begin
          if (fl_q == '0) begin
            state_q <= S_DONE;
          end else begin
            div_rem_q <= '0;
            div_num_q <= {{1'b0, dx_abs, 20'b0} + {16'b0, fl_q[30:1]}, 18'b0};
            div_den_q <= 50'(fl_q);
            div_quo_q <= '0;
            div_cnt_q <= 7'd46;
            ret_q     <= S_P_DXQ;
            state_q   <= S_DIV;
          end
        end
        S_P_DXQ: begin
          dirx_q    <= dx_q[24] ? -div_quo_q[15:0] : div_quo_q[15:0];
          div_rem_q <= '0;
          div_num_q <= {{1'b0, dy_abs, 20'b0} + {16'b0, fl_q[30:1]}, 18'b0};
          div_quo_q <= '0;
          div_cnt_q <= 7'd46;
          ret_q     <= S_P_DYQ;
          state_q   <= S_DIV;
        end
        S_P_DYQ: begin
          diry_q  <= dy_q[24] ? -div_quo_q[15:0] : div_quo_q[15:0];
          state_q <= S_DONE;
        end

        // ---- hand the word to the output register ----
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_status_q <= status_q;
            out_along_q  <= along_q;
            out_px_q     <= px_q;
            out_py_q     <= py_q;
            out_dirx_q   <= dirx_q;
            out_diry_q   <= diry_q;
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // register write restarts loading
      if (cfg_wr) begin
        if (pwdata[8:0] < 9'd2) begin
          n_q <= 9'd2;
        end else if (pwdata[8:0] > 9'(IDX_LIMIT)) begin
          n_q <= 9'(IDX_LIMIT);
        end else begin
          n_q <= pwdata[8:0];
        end
        loaded_q <= '0;
        lap_q    <= '0;
      end
    end
  end

  // ports
  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign along_distance_o = out_along_q;
  assign point_x_o        = out_px_q;
  assign point_y_o        = out_py_q;
  assign dir_x_o          = out_dirx_q;
  assign dir_y_o          = out_diry_q;
  assign prdata           = {23'b0, n_q};
  assign pready           = 1'b1;

  // checks
  `CPLAM_ASSERT_NOW(a_loaded_le_n, 1'b1, loaded_q <= n_q, "loaded count above point count")
  `CPLAM_ASSERT_NEXT(a_accept_busy, in_valid_i && !in_stall_o, state_q != S_IDLE, "accept not held busy")
  `CPLAM_ASSERT_NEXT(a_done_out, (state_q == S_DONE) && (!out_valid_q || !out_stall_i), out_valid_q, "finished word not presented")
  `CPLAM_ASSERT_NOW(a_sqrt_bit, state_q == S_SQRT, $onehot(sq_bit_q), "isqrt bit lost")

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import cplam_pkg::*;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;  // unused command, answered with zeros
  localparam logic [2:0] ADDR_POINT_COUNT = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;
  localparam int PATH_DEPTH = 256;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [QD_W-1:0] qd;
  } path_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [COORD_W-1:0] along;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [DIR_W-1:0] dx;
    logic [DIR_W-1:0] dy;
  } path_answer_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  logic [CMD_W-1:0] command_i;
  logic [IDX_W-1:0] point_index_i;
  logic signed [COORD_W-1:0] x_coord_i, y_coord_i;
  logic signed [QD_W-1:0] query_distance_i;
  logic [STAT_W-1:0] status_o;
  logic [COORD_W-1:0] along_distance_o;
  logic signed [COORD_W-1:0] point_x_o, point_y_o;
  logic signed [DIR_W-1:0] dir_x_o, dir_y_o;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  closed_polyline_arc_length_mapper_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .command_i(command_i), .point_index_i(point_index_i),
    .x_coord_i(x_coord_i), .y_coord_i(y_coord_i), .query_distance_i(query_distance_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .status_o(status_o), .along_distance_o(along_distance_o),
    .point_x_o(point_x_o), .point_y_o(point_y_o),
    .dir_x_o(dir_x_o), .dir_y_o(dir_y_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk_i = 1'b1; #5;
    clk_i = 1'b0; #5;
  end

  // shadow copy of the path
  longint path_x[PATH_DEPTH];
  longint path_y[PATH_DEPTH];
  longint path_cum[PATH_DEPTH];
  longint lap_len;
  int loaded_pts;
  int path_pts;

  path_answer_t pending_answers[$];
  int mismatches;
  int words_sent;
  bit calm_send, calm_recv;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // round half away from zero
  function automatic longint div_rnd(longint num, longint den);
    longint mag;
    mag = num < 0 ? -num : num;
    mag = (mag + den / 2) / den;
    return num < 0 ? -mag : mag;
  endfunction

  // length scaled by 64, floored
  function automatic longint fine_length(longint dx, longint dy);
    longint unsigned sq;
    sq = dx * dx + dy * dy;
    return longint'(int_sqrt(sq << 12));
  endfunction

  function automatic longint seg_length(longint dx, longint dy);
    return (fine_length(dx, dy) + 32) >>> 6;
  endfunction

  function automatic longint sat_dist(longint v);
    return v > longint'(DIST_MAX) ? longint'(DIST_MAX) : v;
  endfunction

  function automatic path_answer_t nearest_arc(longint lx, longint ly);
    path_answer_t a;
    bit have;
    longint best, ax, ay, dx, dy, lsq, dot, t, rem, qx, qy, dsq;
    int j;
    a = '0;
    have = 0;
    best = 0;
    for (int i = 0; i < path_pts; i++) begin
      j = (i + 1 == path_pts) ? 0 : i + 1;
      ax = path_x[i]; ay = path_y[i];
      dx = path_x[j] - ax; dy = path_y[j] - ay;
      lsq = dx * dx + dy * dy;
      dot = (lx - ax) * dx + (ly - ay) * dy;
      t = 0;
      if (lsq == 0 || dot <= 0) t = 0;
      else if (dot >= lsq) t = 65536;
      else begin
        rem = dot;
        for (int k = 0; k < 16; k++) begin
          rem <<= 1; t <<= 1;
          if (rem >= lsq) begin
            rem -= lsq;
            t |= 1;
          end
        end
      end
      qx = ax + div_rnd(dx * t, 65536);
      qy = ay + div_rnd(dy * t, 65536);
      dsq = (lx - qx) * (lx - qx) + (ly - qy) * (ly - qy);
      if (!have || dsq < best) begin
        have = 1;
        best = dsq;
        a.along = sat_dist(path_cum[i] + ((seg_length(dx, dy) * t + 32768) >>> 16));
      end
    end
    return a;
  endfunction

  function automatic path_answer_t point_on_path(longint qd);
    path_answer_t a;
    longint w, fl, len, r, ax, ay, dx, dy, px, py;
    int idx, j;
    a = '0;
    w = 0;
    if (lap_len > 0) begin
      w = qd % lap_len;
      if (w < 0) w += lap_len;
    end
    idx = path_pts - 1;
    for (int c = 0; c + 1 < path_pts; c++) begin
      if (w < path_cum[c + 1]) begin
        idx = c;
        break;
      end
    end
    j = (idx + 1 == path_pts) ? 0 : idx + 1;
    ax = path_x[idx]; ay = path_y[idx];
    dx = path_x[j] - ax; dy = path_y[j] - ay;
    fl = fine_length(dx, dy);
    len = (fl + 32) >>> 6;
    r = w > path_cum[idx] ? w - path_cum[idx] : 0;
    if (len == 0) begin
      px = ax; py = ay;
    end else if (r >= len) begin
      px = ax + dx; py = ay + dy;
    end else begin
      px = ax + div_rnd(dx * r, len);
      py = ay + div_rnd(dy * r, len);
    end
    if (fl > 0) begin
      a.dx = div_rnd(dx * 1048576, fl);
      a.dy = div_rnd(dy * 1048576, fl);
    end
    a.px = px;
    a.py = py;
    a.along = w;
    return a;
  endfunction

  // update the shadow path and queue the answer for one accepted word
  function automatic void predict_answer(path_word_t w);
    path_answer_t a;
    longint lx, ly;
    int pi;
    a = '0;
    lx = w.x;
    ly = w.y;
    pi = w.idx;
    case (w.cmd)
      CMD_LOAD: begin
        if (loaded_pts >= path_pts && pi == 0) begin
          loaded_pts = 0;
          lap_len = 0;
        end
        if (pi != loaded_pts || loaded_pts >= path_pts) begin
          a.status = ST_ORDER;
        end else begin
          path_x[pi] = lx;
          path_y[pi] = ly;
          if (pi == 0) path_cum[0] = 0;
          else path_cum[pi] = sat_dist(path_cum[pi-1] +
                                       seg_length(lx - path_x[pi-1], ly - path_y[pi-1]));
          a.along = path_cum[pi];
          loaded_pts++;
          if (loaded_pts == path_pts)
            lap_len = sat_dist(path_cum[pi] + seg_length(path_x[0] - lx, path_y[0] - ly));
        end
      end
      CMD_ALONG, CMD_POINT: begin
        if (loaded_pts != path_pts) a.status = ST_NOT_LOADED;
        else if (w.cmd == CMD_ALONG) a = nearest_arc(lx, ly);
        else a = point_on_path(longint'(w.qd));
      end
      default: ;
    endcase
    pending_answers.push_back(a);
  endfunction

  function automatic int sender_gap();
    int r;
    if (calm_send) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // send one word; called at a rising edge, returns at a rising edge
  task automatic send_word(path_word_t w);
    int gap;
    in_valid_i <= 1'b1;
    command_i <= w.cmd;
    point_index_i <= w.idx;
    x_coord_i <= w.x;
    y_coord_i <= w.y;
    query_distance_i <= w.qd;
    do @(posedge clk_i); while (in_stall_o);
    predict_answer(w);
    words_sent++;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $signed($urandom_range(0, 4000)) - 2000;
      4, 5, 6: return $signed($urandom_range(0, 400000)) - 200000;
      7: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return $urandom;
    endcase
  endfunction

  function automatic path_word_t make_word(logic [CMD_W-1:0] cmd, int idx);
    path_word_t w;
    w.cmd = cmd;
    w.idx = idx;
    w.x = pick_coord();
    w.y = pick_coord();
    w.qd = $urandom_range(0, 1) ? $signed($urandom_range(0, 20000)) - 5000 : $urandom;
    return w;
  endfunction

  task automatic send_point(int idx, logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
    path_word_t w;
    w = make_word(CMD_LOAD, idx);
    w.x = x;
    w.y = y;
    send_word(w);
  endtask

  task automatic drain_answers();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // register write and read back, only while idle
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    longint v;
    drain_answers();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (addr == ADDR_POINT_COUNT) begin
      v = data & 32'h1FF;
      if (v < 2) v = 2;
      if (v > PATH_DEPTH) v = PATH_DEPTH;
      path_pts = v;
      loaded_pts = 0;
      lap_len = 0;
    end
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b0; paddr <= ADDR_POINT_COUNT;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== 32'(path_pts)) begin
      mismatches++;
      if (mismatches <= 10)
        $display("point_count read: expected %0d got %0d", path_pts, prdata);
    end
    psel <= 1'b0; penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_path(int n);
    for (int i = 0; i < n; i++) send_point(i, pick_coord(), pick_coord());
  endtask

  task automatic test_unloaded();
    send_word(make_word(CMD_ALONG, 0));
    send_word(make_word(CMD_POINT, 0));
    send_word(make_word(CMD_NONE, 5));
    send_point(1, 24'sd100, 24'sd100);
  endtask

  task automatic test_load_order();
    path_word_t w;
    send_point(0, 24'sh800000, 24'sh800000);
    send_point(0, 24'sd5, 24'sd5);
    send_point(1, 24'sh7FFFFF, 24'sh7FFFFF);
    send_point(1, 24'sd0, 24'sd0);
    w = make_word(CMD_ALONG, 0); w.x = 24'sh7FFFFF; w.y = 24'sh800000; send_word(w);
    w = make_word(CMD_POINT, 0); w.qd = 25'sh0FFFFFF; send_word(w);
    w = make_word(CMD_POINT, 0); w.qd = 25'sh1000000; send_word(w);
    send_word(make_word(CMD_NONE, 0));
    // restart with a degenerate path: lap of zero
    send_point(0, 24'sd300, -24'sd300);
    send_point(1, 24'sd300, -24'sd300);
    send_word(make_word(CMD_ALONG, 0));
    w = make_word(CMD_POINT, 0); w.qd = -25'sd77; send_word(w);
    // short path, queries at both ends of the lap
    send_point(0, 24'sd0, 24'sd0);
    send_point(1, 24'sd2560, 24'sd0);
    w = make_word(CMD_POINT, 0); w.qd = 25'sd0; send_word(w);
    w = make_word(CMD_POINT, 0); w.qd = 25'sd5119; send_word(w);
    w = make_word(CMD_POINT, 0); w.qd = -25'sd1; send_word(w);
    w = make_word(CMD_ALONG, 0); w.x = 24'sd1280; w.y = 24'sd9; send_word(w);
  endtask

  task automatic test_config();
    path_word_t w;
    write_reg(ADDR_POINT_COUNT, 32'd0);
    write_reg(ADDR_POINT_COUNT, 32'd1);
    write_reg(ADDR_POINT_COUNT, 32'd300);
    write_reg(ADDR_POINT_COUNT, 32'h1FF);
    write_reg(ADDR_POINT_COUNT, 32'hFFFF_FE03);
    load_path(3);
    // writes beyond the register list leave the path alone
    write_reg(ADDR_UNMAPPED, 32'd7);
    send_word(make_word(CMD_ALONG, 0));
    w = make_word(CMD_POINT, 0); send_word(w);
  endtask

  task automatic test_full_path();
    calm_send = 1;
    calm_recv = 1;
    write_reg(ADDR_POINT_COUNT, 32'd256);
    for (int i = 0; i < PATH_DEPTH; i++)
      send_point(i, $signed($urandom_range(0, 2000)) - 1000,
                 $signed($urandom_range(0, 2000)) - 1000);
    send_point(255, 24'sd1, 24'sd1);
    send_word(make_word(CMD_ALONG, 0));
    send_word(make_word(CMD_POINT, 0));
    calm_send = 0;
    calm_recv = 0;
    send_word(make_word(CMD_ALONG, 0));
    send_word(make_word(CMD_POINT, 0));
    send_word(make_word(CMD_POINT, 0));
  endtask

  task automatic test_random();
    path_word_t w;
    int n;
    while (words_sent < 1250) begin
      calm_send = ($urandom_range(0, 5) == 0);
      calm_recv = ($urandom_range(0, 5) == 0);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(2, 6);
      write_reg(ADDR_POINT_COUNT, n);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0)
          send_word(make_word($urandom_range(0, 3), $urandom_range(0, 255)));
        send_point(i, pick_coord(), pick_coord());
      end
      repeat ($urandom_range(4, 20)) begin
        case ($urandom_range(0, 19))
          0: send_word(make_word(CMD_LOAD, $urandom_range(0, 255)));
          1: send_word(make_word(CMD_NONE, $urandom_range(0, 255)));
          2, 3, 4, 5, 6, 7, 8, 9, 10: send_word(make_word(CMD_ALONG, 0));
          default: send_word(make_word(CMD_POINT, 0));
        endcase
      end
      // reload in place now and then
      if ($urandom_range(0, 3) == 0) begin
        load_path(n);
        send_word(make_word(CMD_POINT, 0));
      end
    end
  endtask

  // receiver stalls: short random ones, sometimes long bursts
  int stall_burst;
  always @(posedge clk_i) begin
    if (!rst_ni || calm_recv) begin
      out_stall_i <= 1'b0;
      stall_burst <= 0;
    end else if (stall_burst > 0) begin
      out_stall_i <= 1'b1;
      stall_burst <= stall_burst - 1;
    end else if ($urandom_range(0, 99) == 0) begin
      out_stall_i <= 1'b1;
      stall_burst <= $urandom_range(10, 60);
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    path_answer_t e, g;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      g = '{status_o, along_distance_o, point_x_o, point_y_o, dir_x_o, dir_y_o};
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", g);
      end else begin
        e = pending_answers.pop_front();
        if (g !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected st=%0d along=%0d p=(%0d,%0d) d=(%0d,%0d) got st=%0d along=%0d p=(%0d,%0d) d=(%0d,%0d)",
                     e.status, e.along, $signed(e.px), $signed(e.py), $signed(e.dx),
                     $signed(e.dy), g.status, g.along, $signed(g.px), $signed(g.py),
                     $signed(g.dx), $signed(g.dy));
        end
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    command_i = '0; point_index_i = '0; x_coord_i = '0; y_coord_i = '0;
    query_distance_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mismatches = 0;
    words_sent = 0;
    calm_send = 0;
    calm_recv = 0;
    path_pts = 2;
    loaded_pts = 0;
    lap_len = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unloaded();
    test_load_order();
    test_config();
    test_full_path();
    test_random();
    drain_answers();
    repeat (400) @(posedge clk_i);
    if (mismatches == 0 && pending_answers.size() == 0)
      $display("[closed_polyline_arc_length_mapper_top] OK");
    else
      $display("[closed_polyline_arc_length_mapper_top] ERROR");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("[closed_polyline_arc_length_mapper_top] ERROR");
    $finish;
  end

endmodule
